// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on i_clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QTSG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QTSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/qtsg_pkg.sv =====
// ----------------------------------------------------------------------------
// qtsg_pkg
// Types, field widths, defaults and the sine table function of the queued
// tone sample generator.
// ----------------------------------------------------------------------------
package qtsg_pkg;

    localparam int DEF_QUEUE_DEPTH  = 16;
    localparam int DEF_SAMPLE_RATE  = 44100;
    localparam int DEF_SINE_ENTRIES = 1024;

    localparam int FREQ_W    = 23;
    localparam int DUR_W     = 16;
    localparam int AMP_W     = 15;
    localparam int SAMPLE_W  = 16;
    localparam int PENDING_W = 5;
    localparam int MAG_W     = 15;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam int MS_PER_S  = 1000;
    localparam int OUT_DEPTH = 8;

    localparam logic [AMP_W-1:0] AMP_RESET = 15'd28000;

    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef struct packed {
        logic [PENDING_W-1:0]       pending;
        logic                       accepted;
        logic signed [SAMPLE_W-1:0] sample;
    } t_result;

    typedef struct packed {
        logic                 active;
        logic                 accepted;
        logic [PENDING_W-1:0] pending;
    } t_flags;

    // Sine of a 32-bit turn fraction as {negative, magnitude} in Q1.15.
    function automatic logic [MAG_W:0] qtsg_sine_turn(input logic [31:0] turn);
        logic [63:0] t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] q;
        logic        neg;
        t   = {32'd0, turn};
        neg = 1'b0;
        if (t >= 64'h8000_0000) begin
            neg = 1'b1;
            t   = t - 64'h8000_0000;
        end
        if (t > 64'h4000_0000) begin
            t = 64'h8000_0000 - t;
        end
        x  = (t * TWO_PI_Q30) >> 32;
        x2 = (x * x) >> 30;
        r  = Q30_ONE;
        r  = Q30_ONE - ((x2 * r) >> 30) / 64'd110;
        r  = Q30_ONE - ((x2 * r) >> 30) / 64'd72;
        r  = Q30_ONE - ((x2 * r) >> 30) / 64'd42;
        r  = Q30_ONE - ((x2 * r) >> 30) / 64'd20;
        r  = Q30_ONE - ((x2 * r) >> 30) / 64'd6;
        s  = (x * r) >> 30;
        q  = (s + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return {neg, q[MAG_W-1:0]};
    endfunction

endpackage

// ===== hdl/qtsg_ram.sv =====
// ----------------------------------------------------------------------------
// qtsg_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module qtsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/queued_tone_sample_generator.sv =====
// ----------------------------------------------------------------------------
// queued_tone_sample_generator
// Note queue in a RAM driving a sine tone generator, one result per item.
// ----------------------------------------------------------------------------
// A result passes the pipeline stages and the output queue before it is valid
// on the master side. Throughput: one item per cycle while the output queue has
// credit, set by the note RAM read-modify-write, which forwards the last write.
// Reset (synchronous, active low) empties the queue, clears the phase and
// loads the default amplitude; the note RAM is not cleared and needs no pass.
module queued_tone_sample_generator
    import qtsg_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int SAMPLE_RATE  = DEF_SAMPLE_RATE,
    parameter int SINE_ENTRIES = DEF_SINE_ENTRIES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tone_freq [22:0], duration_ms [38:23], zero pad [39]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind [0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sample [15:0], accepted [16], pending [21:17], zero pad [23:22]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [AMP_W-1:0]       i_cfg_data
);

    `include "assert_macros.svh"

    localparam int QA_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int PHASE_MOD = SAMPLE_RATE * 256;
    localparam int PHASE_W   = $clog2(PHASE_MOD);
    localparam int FR_W      = (PHASE_W > FREQ_W) ? PHASE_W : FREQ_W;
    localparam int NRED      = ((1 << FREQ_W) - 1) / PHASE_MOD;

    localparam longint unsigned MAX_CNT =
        ((longint'(1) << DUR_W) - 1) * longint'(SAMPLE_RATE) / longint'(MS_PER_S);
    localparam int REM_W   = $clog2(MAX_CNT + 1);
    localparam int ENTRY_W = PHASE_W + REM_W;

    localparam int RATE_INT  = SAMPLE_RATE / MS_PER_S;
    localparam int RATE_FRAC = SAMPLE_RATE % MS_PER_S;
    localparam int MS_L      = $clog2(MS_PER_S);
    localparam int DA_W      = DUR_W + $clog2(RATE_INT + 1);
    localparam int DB_W      = DUR_W + MS_L;
    localparam int DIV_SH    = DB_W + MS_L;
    localparam longint unsigned DIV_RECIP =
        ((longint'(1) << DIV_SH) + longint'(MS_PER_S) - 1) / longint'(MS_PER_S);
    localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
    localparam int DP_W      = DB_W + RECIP_W;

    localparam int IDX_W = (SINE_ENTRIES > 1) ? $clog2(SINE_ENTRIES) : 1;
    localparam int RP_SH = PHASE_W;
    localparam longint unsigned RP =
        (longint'(SINE_ENTRIES) << RP_SH) / longint'(PHASE_MOD);
    localparam int RP_W  = $clog2(RP + 1);
    localparam int PP_W  = PHASE_W + RP_W;
    localparam int PN_W  = PHASE_W + $clog2(SINE_ENTRIES + 1) + 1;

    localparam int OP_W = $clog2(OUT_DEPTH);
    localparam int OC_W = $clog2(OUT_DEPTH + 1);

    // Sine table
    logic [MAG_W:0] w_sine_rom [SINE_ENTRIES];

    for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_sine_rom
        localparam longint unsigned TURN =
            (longint'(g) << 32) / longint'(SINE_ENTRIES);
        assign w_sine_rom[g] = qtsg_sine_turn(32'(TURN));
    end

    // Handshakes and configuration
    logic              w_in_xfer;
    logic              w_out_xfer;
    logic [FREQ_W-1:0] w_in_freq;
    logic [DUR_W-1:0]  w_in_dur;
    logic [AMP_W-1:0]  r_amplitude;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;
    assign w_in_freq  = s_axis_tdata[FREQ_W-1:0];
    assign w_in_dur   = s_axis_tdata[FREQ_W +: DUR_W];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= AMP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_amplitude <= i_cfg_data;
        end
    end

    // Stage 1: captured item and duration products
    logic              r_s1_v;
    logic              r_s1_kind;
    logic [FREQ_W-1:0] r_s1_freq;
    logic              r_s1_dur_nz;
    logic [DA_W-1:0]   r_s1_da;
    logic [DB_W-1:0]   r_s1_db;

    always_ff @(posedge i_clk) begin
        r_s1_kind   <= s_axis_tuser;
        r_s1_freq   <= w_in_freq;
        r_s1_dur_nz <= (w_in_dur != '0);
        r_s1_da     <= DA_W'(w_in_dur) * DA_W'(RATE_INT);
        r_s1_db     <= DB_W'(w_in_dur) * DB_W'(RATE_FRAC);
    end

    // Sample count and frequency reduced to the phase range
    logic [DP_W-1:0]    w_frac_prod;
    logic [DUR_W-1:0]   w_frac;
    logic [REM_W-1:0]   w_cnt;
    logic [FR_W-1:0]    w_freq_fold;
    logic [PHASE_W-1:0] w_freq_red;

    assign w_frac_prod = DP_W'(r_s1_db) * DP_W'(DIV_RECIP);
    assign w_frac      = DUR_W'(w_frac_prod >> DIV_SH);
    assign w_cnt       = REM_W'(r_s1_da) + REM_W'(w_frac);

    always_comb begin
        w_freq_fold = FR_W'(r_s1_freq);
        for (int i = 0; i < NRED; i++) begin
            if (w_freq_fold >= FR_W'(PHASE_MOD)) begin
                w_freq_fold = w_freq_fold - FR_W'(PHASE_MOD);
            end
        end
    end

    assign w_freq_red = PHASE_W'(w_freq_fold);

    // Stage 2: read-modify-write of the note RAM
    logic               r_s2_v;
    logic               r_s2_kind;
    logic               r_s2_dur_nz;
    logic [PHASE_W-1:0] r_s2_freq;
    logic [REM_W-1:0]   r_s2_cnt;

    always_ff @(posedge i_clk) begin
        r_s2_kind   <= r_s1_kind;
        r_s2_dur_nz <= r_s1_dur_nz;
        r_s2_freq   <= w_freq_red;
        r_s2_cnt    <= w_cnt;
    end

    logic [QA_W-1:0]    r_head;
    logic [CNT_W-1:0]   r_count;
    logic [PHASE_W-1:0] r_phase;
    logic [QA_W-1:0]    n_head;
    logic [CNT_W-1:0]   n_count;
    logic [PHASE_W-1:0] n_phase;

    logic               r_fwd_v;
    logic [QA_W-1:0]    r_fwd_addr;
    logic [ENTRY_W-1:0] r_fwd_data;
    logic [QA_W-1:0]    r_rd_addr;
    logic [ENTRY_W-1:0] w_rd_data;
    logic [ENTRY_W-1:0] w_head_entry;
    logic [PHASE_W-1:0] w_head_freq;
    logic [REM_W-1:0]   w_head_rem;
    logic [REM_W-1:0]   w_rem_dec;
    logic [CNT_W:0]     w_tail_sum;
    logic [QA_W-1:0]    w_tail;
    logic [QA_W-1:0]    w_head_inc;
    logic [PHASE_W:0]   w_phase_sum;

    logic               w_wr_en;
    logic [QA_W-1:0]    w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic               w_enq_ok;
    t_flags             w_flags;

    assign w_head_entry = (r_fwd_v && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : w_rd_data;
    assign w_head_freq  = w_head_entry[ENTRY_W-1 -: PHASE_W];
    assign w_head_rem   = w_head_entry[REM_W-1:0];
    assign w_rem_dec    = w_head_rem - REM_W'(1);
    assign w_tail_sum   = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
    assign w_tail       = (w_tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                        ? QA_W'(w_tail_sum - (CNT_W+1)'(QUEUE_DEPTH))
                        : QA_W'(w_tail_sum);
    assign w_head_inc   = (r_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + QA_W'(1);
    assign w_phase_sum  = (PHASE_W+1)'(r_phase) + (PHASE_W+1)'(w_head_freq);
    assign w_enq_ok     = r_s2_v && (r_s2_kind == KIND_ENQUEUE) && r_s2_dur_nz
                        && (r_count < CNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_phase   = r_phase;
        w_wr_en   = 1'b0;
        w_wr_addr = r_head;
        w_wr_data = {w_head_freq, w_rem_dec};
        w_flags.active   = 1'b0;
        w_flags.accepted = 1'b0;
        if (w_enq_ok) begin
            w_wr_en          = 1'b1;
            w_wr_addr        = w_tail;
            w_wr_data        = {r_s2_freq, r_s2_cnt};
            n_count          = r_count + CNT_W'(1);
            w_flags.accepted = 1'b1;
        end else if (r_s2_v && (r_s2_kind == KIND_TICK) && (r_count != '0)) begin
            w_flags.active = 1'b1;
            w_wr_en        = 1'b1;
            if (w_phase_sum >= (PHASE_W+1)'(PHASE_MOD)) begin
                n_phase = PHASE_W'(w_phase_sum - (PHASE_W+1)'(PHASE_MOD));
            end else begin
                n_phase = PHASE_W'(w_phase_sum);
            end
            if (w_rem_dec == '0) begin
                n_head  = w_head_inc;
                n_count = r_count - CNT_W'(1);
            end
        end
        w_flags.pending = PENDING_W'(n_count);
    end

    qtsg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_note_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (n_head),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= w_wr_addr;
        r_fwd_data <= w_wr_data;
        r_rd_addr  <= n_head;
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_phase <= '0;
            r_fwd_v <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_phase <= n_phase;
            r_fwd_v <= w_wr_en;
        end
    end

    // Stage 3: table index estimate
    logic               r_s3_v;
    t_flags             r_s3_flags;
    logic [PHASE_W-1:0] r_s3_phase;
    logic [PP_W-1:0]    w_phase_prod;

    assign w_phase_prod = PP_W'(r_s3_phase) * PP_W'(RP);

    always_ff @(posedge i_clk) begin
        r_s3_flags <= w_flags;
        r_s3_phase <= r_phase;
    end

    // Stage 4: index correction
    logic             r_s4_v;
    t_flags           r_s4_flags;
    logic [IDX_W-1:0] r_s4_q0;
    logic [PN_W-1:0]  r_s4_pn;
    logic [PN_W-1:0]  w_q1m;
    logic [IDX_W-1:0] w_idx;

    always_ff @(posedge i_clk) begin
        r_s4_flags <= r_s3_flags;
        r_s4_q0    <= IDX_W'(w_phase_prod >> RP_SH);
        r_s4_pn    <= PN_W'(r_s3_phase) * PN_W'(SINE_ENTRIES);
    end

    assign w_q1m = PN_W'({1'b0, r_s4_q0} + (IDX_W+1)'(1)) * PN_W'(PHASE_MOD);
    assign w_idx = (w_q1m <= r_s4_pn) ? r_s4_q0 + IDX_W'(1) : r_s4_q0;

    // Stage 5: table read
    logic             r_s5_v;
    t_flags           r_s5_flags;
    logic [IDX_W-1:0] r_s5_idx;

    always_ff @(posedge i_clk) begin
        r_s5_flags <= r_s4_flags;
        r_s5_idx   <= w_idx;
    end

    // Stage 6: amplitude scaling
    logic                  r_s6_v;
    t_flags                r_s6_flags;
    logic [MAG_W:0]        r_s6_sine;
    logic [AMP_W+MAG_W-1:0] w_scaled;
    logic [SAMPLE_W-1:0]   w_mag;
    t_result               w_result;

    always_ff @(posedge i_clk) begin
        r_s6_flags <= r_s5_flags;
        r_s6_sine  <= w_sine_rom[r_s5_idx];
    end

    assign w_scaled = (AMP_W+MAG_W)'(r_amplitude) * (AMP_W+MAG_W)'(r_s6_sine[MAG_W-1:0]);
    assign w_mag    = SAMPLE_W'(w_scaled >> MAG_W);

    always_comb begin
        w_result.pending  = r_s6_flags.pending;
        w_result.accepted = r_s6_flags.accepted;
        if (!r_s6_flags.active) begin
            w_result.sample = '0;
        end else if (r_s6_sine[MAG_W]) begin
            w_result.sample = -w_mag;
        end else begin
            w_result.sample = w_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else begin
            r_s1_v <= w_in_xfer;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
        end
    end

    // Result queue with credit for every item in flight
    t_result         r_fifo [OUT_DEPTH];
    logic [OP_W-1:0] r_wr_ptr;
    logic [OP_W-1:0] r_rd_ptr;
    logic [OC_W-1:0] r_fill;
    logic [OC_W-1:0] r_credit;
    logic [OC_W-1:0] n_fill;
    logic [OC_W-1:0] n_credit;
    t_result         w_out;

    always_comb begin
        n_fill   = r_fill;
        n_credit = r_credit;
        if (r_s6_v) begin
            n_fill = n_fill + OC_W'(1);
        end
        if (w_in_xfer) begin
            n_credit = n_credit + OC_W'(1);
        end
        if (w_out_xfer) begin
            n_fill   = n_fill - OC_W'(1);
            n_credit = n_credit - OC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s6_v) begin
            r_fifo[r_wr_ptr] <= w_result;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            r_fill   <= n_fill;
            r_credit <= n_credit;
            if (r_s6_v) begin
                r_wr_ptr <= r_wr_ptr + OP_W'(1);
            end
            if (w_out_xfer) begin
                r_rd_ptr <= r_rd_ptr + OP_W'(1);
            end
        end
    end

    assign w_out         = r_fifo[r_rd_ptr];
    assign s_axis_tready = (r_credit < OC_W'(OUT_DEPTH));
    assign m_axis_tvalid = (r_fill != '0);
    assign m_axis_tdata  = {{(OUT_TDATA_W - SAMPLE_W - 1 - PENDING_W){1'b0}},
                            w_out.pending, w_out.accepted, w_out.sample};

    // Assertions
    `QTSG_ASSERT_SAME(a_fill_within_credit, 1'b1, r_fill <= r_credit, "queue fill above credit")
    `QTSG_ASSERT_SAME(a_count_bounded, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH), "note count overflow")
    `QTSG_ASSERT_NEXT(a_enqueue_counts, w_enq_ok, r_count == CNT_W'($past(r_count) + 1'b1), "stored note not counted")

endmodule
